@@ design/csbm_pkg.sv @@
// Shared types, constants and mask helpers for the span byte-mask emitter.
`default_nettype none
package csbm_pkg;

  // Default screen geometry
  localparam int unsigned SCREEN_WIDTH_DEF = 256;
  localparam int unsigned SCREEN_ROWS_DEF  = 256;
  // Rows and columns that the 8-bit row and 5-bit byte column can address
  localparam int unsigned ADDR_LIMIT       = 256;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd5;

  // Register reset values
  localparam logic [8:0] CLIP_RIGHT_RST  = 9'd256;
  localparam logic [8:0] CLIP_BOTTOM_RST = 9'd256;

  // Opcodes
  localparam logic OP_FILL   = 1'b0;
  localparam logic OP_INVERT = 1'b1;

  // Write data used by invert
  localparam logic [7:0] INVERT_DATA = 8'hff;
  localparam logic [7:0] FULL_MASK   = 8'hff;

  // Configuration register set
  typedef struct packed {
    logic signed [10:0] offset_x;
    logic signed [10:0] offset_y;
    logic [8:0]         clip_left;
    logic [8:0]         clip_right;
    logic [8:0]         clip_top;
    logic [8:0]         clip_bottom;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture a span and add offsets
    logic clip;  // clip the span and set up the byte walk
    logic step;  // emit one byte write
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;    // span dropped or clipped away
    logic at_last;  // current byte is the last of the span
  } sts_t;

  // Mask of the first byte: pixels from lo to the right edge
  function automatic logic [7:0] lead_mask(input logic [2:0] lo);
    return FULL_MASK >> lo;
  endfunction

  // Mask of the last byte: pixels from the left edge through hi
  function automatic logic [7:0] tail_mask(input logic [2:0] hi);
    return FULL_MASK << (3'd7 - hi);
  endfunction

endpackage
`default_nettype wire

@@ design/csbm_cfg_regs.sv @@
// Configuration register file with index decode.
`default_nettype none
module csbm_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [csbm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [csbm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output csbm_pkg::cfg_t                         cfg_o
);

  csbm_pkg::cfg_t cfg_q;

  // Write decode; indexes past the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_x    <= '0;
      cfg_q.offset_y    <= '0;
      cfg_q.clip_left   <= '0;
      cfg_q.clip_right  <= csbm_pkg::CLIP_RIGHT_RST;
      cfg_q.clip_top    <= '0;
      cfg_q.clip_bottom <= csbm_pkg::CLIP_BOTTOM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        csbm_pkg::REG_OFFSET_X:    cfg_q.offset_x    <= cfg_data_i;
        csbm_pkg::REG_OFFSET_Y:    cfg_q.offset_y    <= cfg_data_i;
        csbm_pkg::REG_CLIP_LEFT:   cfg_q.clip_left   <= cfg_data_i[8:0];
        csbm_pkg::REG_CLIP_RIGHT:  cfg_q.clip_right  <= cfg_data_i[8:0];
        csbm_pkg::REG_CLIP_TOP:    cfg_q.clip_top    <= cfg_data_i[8:0];
        csbm_pkg::REG_CLIP_BOTTOM: cfg_q.clip_bottom <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ design/csbm_ctrl.sv @@
// Controller: sequences load, clip and the per-byte emit walk.
`default_nettype none
module csbm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire csbm_pkg::sts_t sts_i,
  output csbm_pkg::cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CLIP = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_CLIP;
      end
      ST_CLIP: begin
        state_d = sts_i.empty ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.at_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands
  assign busy       = (state_q != ST_IDLE);
  assign cmd_o.load = (state_q == ST_IDLE) && start;
  assign cmd_o.clip = (state_q == ST_CLIP);
  assign cmd_o.step = (state_q == ST_EMIT);

endmodule
`default_nettype wire

@@ design/csbm_datapath.sv @@
// Datapath: offset add, clip, byte walk and the output beat register.
`default_nettype none
module csbm_datapath #(
  parameter int unsigned SCREEN_WIDTH = csbm_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_ROWS  = csbm_pkg::SCREEN_ROWS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire csbm_pkg::cfg_t     cfg_i,
  input  wire csbm_pkg::cmd_t     cmd_i,
  output csbm_pkg::sts_t          sts_o,
  input  wire logic               opcode_i,
  input  wire logic signed [10:0] span_x_i,
  input  wire logic signed [10:0] span_y_i,
  input  wire logic [9:0]         pixel_count_i,
  input  wire logic [3:0]         colour_i,
  output logic                    res_strobe_o,
  output logic [7:0]              row_index_o,
  output logic [4:0]              byte_column_o,
  output logic [7:0]              bit_mask_o,
  output logic [7:0]              write_data_o,
  output logic                    xor_mode_o,
  output logic                    last_write_o
);

  // Screen caps folded with the addressable range
  localparam int unsigned COL_CAP =
    (SCREEN_WIDTH < csbm_pkg::ADDR_LIMIT) ? SCREEN_WIDTH : csbm_pkg::ADDR_LIMIT;
  localparam int unsigned ROW_CAP =
    (SCREEN_ROWS < csbm_pkg::ADDR_LIMIT) ? SCREEN_ROWS : csbm_pkg::ADDR_LIMIT;

  // Captured span
  logic signed [11:0] x_q, y_q;
  logic [9:0]         cnt_q;
  logic [7:0]         data_q;
  logic               xor_q;

  // Byte walk
  logic [4:0] col_q, last_col_q;
  logic [2:0] lo_q, hi_q;
  logic       first_q;

  // Output beat
  logic       strobe_q;
  logic [7:0] row_q, mask_q, wdata_q;
  logic [4:0] bcol_q;
  logic       xmode_q, last_q;

  // Clip arithmetic
  logic [8:0]         col_lim, row_lim;
  logic signed [12:0] x13, xe13, y13, left13, right13, top13, bot13;
  logic signed [12:0] start13, end13, endm1;
  logic               row_ok, empty;
  logic [7:0]         mask_d;

  assign col_lim = (cfg_i.clip_right < 9'(COL_CAP)) ? cfg_i.clip_right : 9'(COL_CAP);
  assign row_lim = (cfg_i.clip_bottom < 9'(ROW_CAP)) ? cfg_i.clip_bottom : 9'(ROW_CAP);

  assign x13     = {x_q[11], x_q};
  assign y13     = {y_q[11], y_q};
  assign xe13    = x13 + $signed({3'b000, cnt_q});
  assign left13  = $signed({4'b0000, cfg_i.clip_left});
  assign right13 = $signed({4'b0000, col_lim});
  assign top13   = $signed({4'b0000, cfg_i.clip_top});
  assign bot13   = $signed({4'b0000, row_lim});

  // Span clipped to [start, end); empty when nothing remains
  assign start13 = (x13 < left13) ? left13 : x13;
  assign end13   = (xe13 < right13) ? xe13 : right13;
  assign endm1   = end13 - 13'sd1;
  assign row_ok  = (y13 >= top13) && (y13 < bot13);
  assign empty   = !row_ok || (end13 <= start13);

  assign sts_o.empty   = empty;
  assign sts_o.at_last = (col_q == last_col_q);

  // Capture span with offsets added
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= {span_x_i[10], span_x_i} + {cfg_i.offset_x[10], cfg_i.offset_x};
      y_q    <= {span_y_i[10], span_y_i} + {cfg_i.offset_y[10], cfg_i.offset_y};
      cnt_q  <= pixel_count_i;
      xor_q  <= (opcode_i == csbm_pkg::OP_INVERT);
      data_q <= (opcode_i == csbm_pkg::OP_INVERT) ? csbm_pkg::INVERT_DATA
                                                  : {4'b0000, colour_i};
    end
  end

  // Byte walk setup and advance
  always_ff @(posedge clk_i) begin
    if (cmd_i.clip) begin
      col_q      <= start13[7:3];
      lo_q       <= start13[2:0];
      last_col_q <= endm1[7:3];
      hi_q       <= endm1[2:0];
      first_q    <= 1'b1;
    end else if (cmd_i.step) begin
      col_q   <= col_q + 5'd1;
      first_q <= 1'b0;
    end
  end

  // Mask of the current byte
  always_comb begin
    mask_d = csbm_pkg::FULL_MASK;
    if (first_q) mask_d = mask_d & csbm_pkg::lead_mask(lo_q);
    if (sts_o.at_last) mask_d = mask_d & csbm_pkg::tail_mask(hi_q);
  end

  // Output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      row_q   <= y_q[7:0];
      bcol_q  <= col_q;
      mask_q  <= mask_d;
      wdata_q <= data_q;
      xmode_q <= xor_q;
      last_q  <= sts_o.at_last;
    end
  end

  assign res_strobe_o  = strobe_q;
  assign row_index_o   = row_q;
  assign byte_column_o = bcol_q;
  assign bit_mask_o    = mask_q;
  assign write_data_o  = wdata_q;
  assign xor_mode_o    = xmode_q;
  assign last_write_o  = last_q;

endmodule
`default_nettype wire

@@ design/clipped_span_byte_mask_emitter.sv @@
// Top level of the clipped span byte-mask emitter.
//
// Channel   Direction  Handshake                 Payload
// span      in         start && !busy            opcode, span_x, span_y, pixel_count, colour
// result    out        res_strobe_o, one cycle   row_index, byte_column, bit_mask,
//                                                write_data, xor_mode, last_write
// config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A span of n byte writes (n <= 32) has its offsets added as it is taken, is
// then clipped, and then gets one byte write per cycle from the emit walk.
// A dropped or fully clipped span returns to idle after the clip and makes no beat.
// Each beat appears in the cycle after its emit cycle; busy falls with the last
// emit cycle, so the next span may be taken while the last beat is shown.
// Reset is asynchronous and restores the register defaults; the receiver
// cannot stall, so results are never held.
`default_nettype none
module clipped_span_byte_mask_emitter #(
  parameter int unsigned SCREEN_WIDTH = csbm_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_ROWS  = csbm_pkg::SCREEN_ROWS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // span command
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             opcode_i,
  input  wire logic signed [10:0]               span_x_i,
  input  wire logic signed [10:0]               span_y_i,
  input  wire logic [9:0]                       pixel_count_i,
  input  wire logic [3:0]                       colour_i,
  // byte writes
  output logic                                  res_strobe_o,
  output logic [7:0]                            row_index_o,
  output logic [4:0]                            byte_column_o,
  output logic [7:0]                            bit_mask_o,
  output logic [7:0]                            write_data_o,
  output logic                                  xor_mode_o,
  output logic                                  last_write_o,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [csbm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [csbm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  csbm_pkg::cfg_t cfg;
  csbm_pkg::cmd_t cmd;
  csbm_pkg::sts_t sts;

  csbm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  csbm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  csbm_datapath #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_ROWS  (SCREEN_ROWS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (opcode_i),
    .span_x_i      (span_x_i),
    .span_y_i      (span_y_i),
    .pixel_count_i (pixel_count_i),
    .colour_i      (colour_i),
    .res_strobe_o  (res_strobe_o),
    .row_index_o   (row_index_o),
    .byte_column_o (byte_column_o),
    .bit_mask_o    (bit_mask_o),
    .write_data_o  (write_data_o),
    .xor_mode_o    (xor_mode_o),
    .last_write_o  (last_write_o)
  );

  // Beats of one span come back to back until the last one
  a_beats_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !last_write_o |=> res_strobe_o)
    else $error("span beats not contiguous");

  // A newly taken span makes no beat in the clip cycle
  a_no_beat_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !res_strobe_o)
    else $error("beat in the cycle after accept");

  // Taking a span raises busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy low after accept");

  // Every beat follows a busy cycle
  a_beat_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(busy))
    else $error("beat without work in progress");

endmodule
`default_nettype wire

@@ verif/clipped_span_byte_mask_emitter_tb.sv @@
// Testbench for the clipped span byte-mask emitter: scoreboard, stimulus and checks.
`timescale 1ns / 100ps
module clipped_span_byte_mask_emitter_tb;

  localparam int SCR_W          = csbm_pkg::SCREEN_WIDTH_DEF;
  localparam int SCR_H          = csbm_pkg::SCREEN_ROWS_DEF;
  localparam int MAX_REPORTS    = 10;
  localparam int WATCHDOG_LIMIT = 500;
  // a dropped span raises busy through the clip state with no beat
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  // indexes past the register file, writes there are ignored
  localparam logic [csbm_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [csbm_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [7:0] row;
    logic [4:0] col;
    logic [7:0] mask;
    logic [7:0] data;
    logic       xr;
    logic       last;
  } write_t;

  // Predicts byte writes per span and holds them until the block emits them
  class byte_write_board;
    write_t             expected_writes[$];
    logic signed [10:0] off_x, off_y;
    logic [8:0]         clip_l, clip_r, clip_t, clip_b;
    int                 fails;

    function new();
      off_x  = '0;
      off_y  = '0;
      clip_l = '0;
      clip_r = csbm_pkg::CLIP_RIGHT_RST;
      clip_t = '0;
      clip_b = csbm_pkg::CLIP_BOTTOM_RST;
      fails  = 0;
    endfunction

    function void set_reg(logic [csbm_pkg::CFG_IDX_W-1:0] idx,
                          logic [csbm_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        csbm_pkg::REG_OFFSET_X:    off_x  = d;
        csbm_pkg::REG_OFFSET_Y:    off_y  = d;
        csbm_pkg::REG_CLIP_LEFT:   clip_l = d[8:0];
        csbm_pkg::REG_CLIP_RIGHT:  clip_r = d[8:0];
        csbm_pkg::REG_CLIP_TOP:    clip_t = d[8:0];
        csbm_pkg::REG_CLIP_BOTTOM: clip_b = d[8:0];
        default: ;
      endcase
    endfunction

    function int min_of3(int a, int b, int c);
      int m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
    endfunction

    function int row_limit();
      return min_of3(int'(clip_b), SCR_H, csbm_pkg::ADDR_LIMIT);
    endfunction

    function int col_limit();
      return min_of3(int'(clip_r), SCR_W, csbm_pkg::ADDR_LIMIT);
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction

    function void note_span(logic op, logic signed [10:0] sx, logic signed [10:0] sy,
                            logic [9:0] cnt, logic [3:0] colour);
      int     x, y, n, left, end_px, first_b, last_b, lo, hi;
      write_t w;
      x = int'($signed(sx)) + int'($signed(off_x));
      y = int'($signed(sy)) + int'($signed(off_y));
      n = int'(cnt);
      left = int'(clip_l);
      // vertical clip drops the whole span
      if (y < int'(clip_t) || y >= row_limit()) return;
      if (x < left) begin
        n -= left - x;
        x = left;
      end
      if (x + n > col_limit()) n = col_limit() - x;
      if (n <= 0) return;
      end_px  = x + n;
      first_b = x >> 3;
      last_b  = (end_px - 1) >> 3;
      for (int b = first_b; b <= last_b; b++) begin
        lo     = (b == first_b) ? (x & 7) : 0;
        hi     = (b == last_b) ? ((end_px - 1) & 7) + 1 : 8;
        w.row  = 8'(y);
        w.col  = 5'(b);
        w.mask = 8'((255 >> lo) & ~(255 >> hi));
        w.data = (op == csbm_pkg::OP_INVERT) ? csbm_pkg::INVERT_DATA : {4'h0, colour};
        w.xr   = (op == csbm_pkg::OP_INVERT);
        w.last = (b == last_b);
        expected_writes.push_back(w);
      end
    endfunction

    function void report(string what, write_t want, write_t got);
      fails++;
      if (fails <= MAX_REPORTS) begin
        $display("%s: exp row %0d col %0d mask %02h data %02h xor %b last %b",
                 what, want.row, want.col, want.mask, want.data, want.xr, want.last);
        $display("  got row %0d col %0d mask %02h data %02h xor %b last %b",
                 got.row, got.col, got.mask, got.data, got.xr, got.last);
      end
    endfunction

    function void check_write(write_t got);
      write_t want;
      if (expected_writes.size() == 0) begin
        report("unexpected beat", '0, got);
        return;
      end
      want = expected_writes.pop_front();
      if (got !== want) report("beat mismatch", want, got);
    endfunction

    function void count_leftover();
      while (expected_writes.size() != 0)
        report("missing beat", expected_writes.pop_front(), '0);
    endfunction
  endclass

  logic                            clk_i, rst_ni;
  logic                            start, busy;
  logic                            opcode_i;
  logic signed [10:0]              span_x_i, span_y_i;
  logic [9:0]                      pixel_count_i;
  logic [3:0]                      colour_i;
  logic                            res_strobe_o;
  logic [7:0]                      row_index_o;
  logic [4:0]                      byte_column_o;
  logic [7:0]                      bit_mask_o;
  logic [7:0]                      write_data_o;
  logic                            xor_mode_o;
  logic                            last_write_o;
  logic                            cfg_we_i;
  logic [csbm_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [csbm_pkg::CFG_DATA_W-1:0] cfg_data_i;

  byte_write_board sb;
  int              quiet_cycles;

  clipped_span_byte_mask_emitter #(
    .SCREEN_WIDTH(SCR_W),
    .SCREEN_ROWS (SCR_H)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .span_x_i     (span_x_i),
    .span_y_i     (span_y_i),
    .pixel_count_i(pixel_count_i),
    .colour_i     (colour_i),
    .res_strobe_o (res_strobe_o),
    .row_index_o  (row_index_o),
    .byte_column_o(byte_column_o),
    .bit_mask_o   (bit_mask_o),
    .write_data_o (write_data_o),
    .xor_mode_o   (xor_mode_o),
    .last_write_o (last_write_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Monitor: note accepted spans, check beats, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && busy === 1'b0) begin
        sb.note_span(opcode_i, span_x_i, span_y_i, pixel_count_i, colour_i);
        quiet_cycles = 0;
      end else if (res_strobe_o !== 1'b0) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (res_strobe_o !== 1'b0)
        sb.check_write({row_index_o, byte_column_o, bit_mask_o, write_data_o,
                        xor_mode_o, last_write_o});
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Present one span and hold it until accepted; optional idle gap after
  task automatic send_span(int op, int x, int y, int cnt, int colour, int idle_pct);
    opcode_i      <= 1'(op);
    span_x_i      <= 11'(x);
    span_y_i      <= 11'(y);
    pixel_count_i <= 10'(cnt);
    colour_i      <= 4'(colour);
    start         <= 1'b1;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 40 : 5)) @(posedge clk_i);
    end
  endtask

  // Leave the write enable high; the caller lowers it after the last write
  task automatic write_reg(logic [csbm_pkg::CFG_IDX_W-1:0] idx, int d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 11'(d);
    @(posedge clk_i);
    sb.set_reg(idx, 11'(d));
  endtask

  // Clip registers get random upper data bits, which the block drops
  task automatic program_regs(int ox, int oy, int cl, int cr, int ct, int cb);
    write_reg(csbm_pkg::REG_OFFSET_X, ox);
    write_reg(csbm_pkg::REG_OFFSET_Y, oy);
    write_reg(csbm_pkg::REG_CLIP_LEFT,   ($urandom_range(3) << 9) | cl);
    write_reg(csbm_pkg::REG_CLIP_RIGHT,  ($urandom_range(3) << 9) | cr);
    write_reg(csbm_pkg::REG_CLIP_TOP,    ($urandom_range(3) << 9) | ct);
    write_reg(csbm_pkg::REG_CLIP_BOTTOM, ($urandom_range(3) << 9) | cb);
    write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom_range(2047));
    cfg_we_i <= 1'b0;
  endtask

  // Wait for all beats plus the tail of a possibly dropped span
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic random_setup(int ph);
    int ox, oy, cl, cr, ct, cb;
    ox = $urandom_range(600) - 300;
    oy = $urandom_range(400) - 200;
    cl = $urandom_range(120);
    cr = $urandom_range(256, cl + 1);
    ct = $urandom_range(200);
    cb = $urandom_range(256, ct + 1);
    case (ph)
      // limits past the screen edge
      4: begin
        cr = $urandom_range(511, 257);
        cb = $urandom_range(511, 257);
      end
      // narrow strip at the right edge
      6: begin
        cl = $urandom_range(256, 240);
        cr = 256;
      end
      // x offset at an extreme, y offset at 255 or at its minimum
      8: begin
        ox = $urandom_range(1) ? 1023 : -1024;
        oy = $urandom_range(1) ? 255 : -1024;
        ct = 0;
        cb = 256;
      end
      default: ;
    endcase
    program_regs(ox, oy, cl, cr, ct, cb);
  endtask

  // Mostly spans aimed at the visible window, the rest raw noise
  task automatic send_random(int idle_pct);
    int sx, sy, cnt, rl, cw, ty, tx, k;
    sx = $urandom_range(2047) - 1024;
    sy = $urandom_range(2047) - 1024;
    if ($urandom_range(99) < 78) begin
      rl = sb.row_limit();
      if (rl > int'(sb.clip_t)) begin
        ty = $urandom_range(rl - 1, int'(sb.clip_t));
        k  = ty - int'($signed(sb.off_y));
        if (k >= -1024 && k <= 1023) sy = k;
      end
      cw = sb.col_limit() - int'(sb.clip_l);
      cw = (cw > 0) ? cw + 16 : 16;
      tx = int'(sb.clip_l) - 12 + $urandom_range(cw);
      k  = tx - int'($signed(sb.off_x));
      if (k >= -1024 && k <= 1023) sx = k;
    end
    k = $urandom_range(99);
    if (k < 70) cnt = $urandom_range(40);
    else if (k < 90) cnt = $urandom_range(300);
    else cnt = $urandom_range(1023);
    send_span($urandom_range(1), sx, sy, cnt, $urandom_range(15), idle_pct);
  endtask

  function automatic int idle_for(int ph);
    case (ph % 4)
      1: return 61;
      3: return 14;
      default: return 0;
    endcase
  endfunction

  initial begin
    sb            = new();
    quiet_cycles  = 0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    opcode_i      = csbm_pkg::OP_FILL;
    span_x_i      = '0;
    span_y_i      = '0;
    pixel_count_i = '0;
    colour_i      = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = csbm_pkg::REG_OFFSET_X;
    cfg_data_i    = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed spans on the reset window
    send_span(csbm_pkg::OP_FILL,     0,     0,    8, 15, 0);  // one aligned byte
    send_span(csbm_pkg::OP_INVERT,   3,     1,    2,  0, 0);  // partial inside a byte
    send_span(csbm_pkg::OP_FILL,    10,     2,    0,  5, 0);  // zero count
    send_span(csbm_pkg::OP_FILL,     0,     3, 1023, 10, 0);  // full row after right clip
    send_span(csbm_pkg::OP_INVERT,   1,     4, 1023, 15, 0);  // unaligned, right clip
    send_span(csbm_pkg::OP_FILL, -1024,     5, 1023,  1, 0);  // ends left of the screen
    send_span(csbm_pkg::OP_FILL,    -5,     6,   10,  3, 0);  // negative start
    send_span(csbm_pkg::OP_FILL,  1023,     7,    5, 12, 0);  // right of the screen
    send_span(csbm_pkg::OP_FILL,    20,    -1,    4,  7, 0);  // row above
    send_span(csbm_pkg::OP_FILL,    20,   255,    4,  9, 0);  // bottom row
    send_span(csbm_pkg::OP_INVERT,  20,   256,    4,  2, 0);  // row past the bottom
    send_span(csbm_pkg::OP_FILL,    20,  1023,    4,  4, 0);
    send_span(csbm_pkg::OP_FILL,    20, -1024,    4,  6, 0);
    send_span(csbm_pkg::OP_FILL,   250,     8,   20,  8, 0);  // crosses the right edge
    send_span(csbm_pkg::OP_FILL,     7,     9,    1, 11, 0);  // last pixel of a byte
    send_span(csbm_pkg::OP_INVERT,   5,    10,    3, 13, 0);  // ends on a byte boundary
    send_span(csbm_pkg::OP_FILL,     8,    11,   17, 14, 0);
    send_span(csbm_pkg::OP_FILL,   255,    12,    1,  1, 0);  // final pixel
    send_span(csbm_pkg::OP_FILL,     0,    13,  256,  0, 0);  // exact full row

    // Inverted clip window with extreme offsets: everything dropped
    settle();
    program_regs(-1024, 1023, 256, 0, 256, 0);
    send_span(csbm_pkg::OP_FILL,   1023, -1024, 1023, 15, 0);
    send_span(csbm_pkg::OP_INVERT,  200,  -900,  100,  0, 0);

    // Last row only, left strip of one byte
    settle();
    program_regs(1023, 255, 0, 8, 255, 256);
    send_span(csbm_pkg::OP_FILL,   -1024,    0,    5,  5, 0);
    send_span(csbm_pkg::OP_INVERT, -1020,    0, 1023, 10, 0);
    send_span(csbm_pkg::OP_FILL,   -1024,    1,    4,  3, 0);  // row past the limit
    send_span(csbm_pkg::OP_FILL,   -1024, -256,    4,  3, 0);  // row above clip_top

    // Random phases, each with its own window and one of three idle settings
    for (int ph = 3; ph < 9; ph++) begin
      settle();
      random_setup(ph);
      for (int i = 0; i < 32; i++) begin
        if (ph == 5 && i == 16) begin
          // hold off until the block has drained
          settle();
        end
        send_random(idle_for(ph));
      end
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.count_leftover();
    if (sb.fails == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
